FILE: rtl/mecanum_joystick_command_mixer_defines.svh
// ----------------------------------------------------------------------------
// Mecanum joystick command mixer assertion macros
// Shared concurrent assertion forms for the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef MECANUM_JOYSTICK_COMMAND_MIXER_DEFINES_SVH
`define MECANUM_JOYSTICK_COMMAND_MIXER_DEFINES_SVH

// same-cycle implication
`define MJCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mjcm check failed");

// next-cycle implication
`define MJCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mjcm check failed");

`endif

FILE: rtl/mjcm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum joystick command mixer package
// Payload and config types, control codes, constants and lookup tables.
// ----------------------------------------------------------------------------
package mjcm_pkg;

   localparam int TIME_W          = 32;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   localparam int TILT_LOW        = 20;
   localparam int TILT_CENTER     = 80;
   localparam int TILT_HIGH       = 95;
   localparam int PAN_MAX         = 180;
   localparam int RANGE_PERIOD_MS = 100;

   localparam int AXIS_FULL       = 100;
   localparam int AXIS_RAW_DIV    = 128;
   localparam int STICK_OFFSET    = 128;
   localparam int PAN_DIV         = 255;
   localparam int TILT_POS_DIV    = 127;
   localparam int TILT_NEG_DIV    = 128;
   localparam int CMD_LIMIT       = 100;
   localparam int RANGE_BYTE_MAX  = 255;

   // shared multiplier and divide-by-100 reciprocal
   localparam int MUL_A_W         = 15;
   localparam int MUL_B_W         = 13;
   localparam int PROD_W          = MUL_A_W + MUL_B_W;
   localparam int PCT_DIV         = 100;
   localparam int DIV100_SHIFT    = 19;
   localparam logic [MUL_B_W-1:0] DIV100_RECIP =
      MUL_B_W'(((2 ** DIV100_SHIFT) + PCT_DIV - 1) / PCT_DIV);
   localparam int QUOT_W          = PROD_W - DIV100_SHIFT;
   localparam int SUM_W           = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_JOY_DEADZONE  = 3'd0,
      CSR_TURN_RATE     = 3'd1,
      CSR_NEAR_THRESH   = 3'd2,
      CSR_LINK_TIMEOUT  = 3'd3,
      CSR_TICK_MS       = 3'd4,
      CSR_FORWARD_COMP  = 3'd5,
      CSR_STRAFE_COMP   = 3'd6,
      CSR_TILT_DEADZONE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_STOP       = 2'd0,
      MODE_SPIN_LEFT  = 2'd1,
      MODE_SPIN_RIGHT = 2'd2,
      MODE_MECANUM    = 2'd3
   } drive_mode_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_TY_FC,
      MUL_RECIP,
      MUL_AX_SC
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              capture;
      mul_op_type        mul_op;
      logic              adjust_x;
      logic              load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [6:0]  joy_deadzone;
      logic [6:0]  turn_rate;
      logic [15:0] near_threshold_cm;
      logic [15:0] link_timeout_ms;
      logic [9:0]  tick_ms;
      logic [6:0]  forward_comp_pct;
      logic [6:0]  strafe_comp_pct;
      logic [6:0]  tilt_deadzone;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      joy_deadzone:      7'd10,
      turn_rate:         7'd60,
      near_threshold_cm: 16'd15,
      link_timeout_ms:   16'd500,
      tick_ms:           10'd20,
      forward_comp_pct:  7'd16,
      strafe_comp_pct:   7'd6,
      tilt_deadzone:     7'd8
   };

   typedef struct packed {
      logic               frame_arrived;
      logic signed [7:0]  joy_x;
      logic signed [7:0]  joy_y;
      logic               spin_left_button;
      logic               spin_right_button;
      logic signed [7:0]  pan_stick;
      logic signed [7:0]  tilt_stick;
      logic [15:0]        range_cm;
      logic               range_failed;
   } req_type;

   typedef struct packed {
      drive_mode_type     drive_mode;
      logic signed [7:0]  drive_x;
      logic signed [7:0]  drive_y;
      logic [6:0]         drive_speed;
      logic               servo_update;
      logic [7:0]         pan_angle;
      logic [7:0]         tilt_angle;
      logic               range_report;
      logic [7:0]         range_byte;
      logic               near_alarm;
      logic               link_online;
   } rsp_type;

   typedef logic [255:0][7:0] lut8_type;

   function automatic int raw_to_int(int code);
      return (code < 128) ? code : code - 256;
   endfunction

   // axis scale to -100..99, truncating toward zero
   function automatic lut8_type build_scale_lut();
      lut8_type t;
      int       r;
      for (int i = 0; i < 256; i++) begin
         r = (raw_to_int(i) * AXIS_FULL) / AXIS_RAW_DIV;
         if (r > CMD_LIMIT) r = CMD_LIMIT;
         if (r < -CMD_LIMIT) r = -CMD_LIMIT;
         t[i] = 8'(r);
      end
      return t;
   endfunction

   function automatic lut8_type build_pan_lut();
      lut8_type t;
      int       r;
      for (int i = 0; i < 256; i++) begin
         r = ((raw_to_int(i) + STICK_OFFSET) * PAN_MAX) / PAN_DIV;
         if (r < 0) r = 0;
         if (r > PAN_MAX) r = PAN_MAX;
         t[i] = 8'(r);
      end
      return t;
   endfunction

   // center-anchored tilt, center clamped low first then high
   function automatic lut8_type build_tilt_lut();
      lut8_type t;
      int       c;
      int       v;
      int       r;
      c = TILT_CENTER;
      if (c < TILT_LOW) c = TILT_LOW;
      if (c > TILT_HIGH) c = TILT_HIGH;
      for (int i = 0; i < 256; i++) begin
         v = raw_to_int(i);
         if (v >= 0) r = c + (v * (TILT_HIGH - c)) / TILT_POS_DIV;
         else r = c + (v * (c - TILT_LOW)) / TILT_NEG_DIV;
         if (r < TILT_LOW) r = TILT_LOW;
         if (r > TILT_HIGH) r = TILT_HIGH;
         t[i] = 8'(r);
      end
      return t;
   endfunction

   localparam lut8_type SCALE_LUT = build_scale_lut();
   localparam lut8_type PAN_LUT   = build_pan_lut();
   localparam lut8_type TILT_LUT  = build_tilt_lut();

endpackage

FILE: rtl/mjcm_csr.sv
// ----------------------------------------------------------------------------
// Mixer configuration registers
// Holds the eight tuning registers, written through the csr channel.
// ----------------------------------------------------------------------------
module mjcm_csr import mjcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;

   assign csr_ready = 1'b1;
   assign index     = csr_index_type'(csr_index);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (index)
            CSR_JOY_DEADZONE:  cfg_in.joy_deadzone      = csr_data[6:0];
            CSR_TURN_RATE:     cfg_in.turn_rate         = csr_data[6:0];
            CSR_NEAR_THRESH:   cfg_in.near_threshold_cm = csr_data;
            CSR_LINK_TIMEOUT:  cfg_in.link_timeout_ms   = csr_data;
            CSR_TICK_MS:       cfg_in.tick_ms           = csr_data[9:0];
            CSR_FORWARD_COMP:  cfg_in.forward_comp_pct  = csr_data[6:0];
            CSR_STRAFE_COMP:   cfg_in.strafe_comp_pct   = csr_data[6:0];
            CSR_TILT_DEADZONE: cfg_in.tilt_deadzone     = csr_data[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/mjcm_ctrl.sv
// ----------------------------------------------------------------------------
// Mixer controller
// Sequences capture, the four multiplier passes and the result load.
// ----------------------------------------------------------------------------
`include "mecanum_joystick_command_mixer_defines.svh"

module mjcm_ctrl import mjcm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL_A;
         ST_MUL_A:  state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_MUL_C;
         ST_MUL_C:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_FINISH;
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{capture: 1'b0, mul_op: MUL_NONE, adjust_x: 1'b0, load_out: 1'b0};
      case (state_ff)
         ST_IDLE:   cmd.capture = req_valid;
         ST_MUL_A:  cmd.mul_op = MUL_TY_FC;
         ST_MUL_B:  cmd.mul_op = MUL_RECIP;
         ST_MUL_C: begin
            cmd.mul_op   = MUL_AX_SC;
            cmd.adjust_x = 1'b1;
         end
         ST_MUL_D:  cmd.mul_op = MUL_RECIP;
         ST_FINISH: cmd.load_out = slot_free;
         default:   cmd.capture = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MJCM_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_valid && req_ready, state_ff == ST_MUL_A)
   `MJCM_ASSERT_NEXT(a_accept_blocks_next, clock, reset, req_valid && req_ready, !req_ready)
   `MJCM_ASSERT_NEXT(a_finish_holds, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_ready, state_ff == ST_FINISH)

endmodule

FILE: rtl/mjcm_datapath.sv
// ----------------------------------------------------------------------------
// Mixer datapath
// Link and range timekeeping, drive mixing over a shared multiplier,
// servo lookups and the result register.
// ----------------------------------------------------------------------------
`include "mecanum_joystick_command_mixer_defines.svh"

module mjcm_datapath import mjcm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  cfg_type      cfg,
   input  req_type      req_data,
   output rsp_type      rsp_data
);

   localparam logic signed [SUM_W-1:0] CMD_HI = SUM_W'(CMD_LIMIT);
   localparam logic signed [SUM_W-1:0] CMD_LO = -SUM_W'(CMD_LIMIT);

   function automatic logic signed [7:0] apply_deadzone(logic signed [7:0] v,
                                                        logic [6:0] dz);
      logic signed [8:0] v9;
      logic signed [8:0] d9;
      v9 = {v[7], v};
      d9 = {2'b00, dz};
      if (v9 > -d9 && v9 < d9) return 8'sd0;
      return v;
   endfunction

   function automatic logic signed [7:0] clamp_cmd(logic signed [SUM_W-1:0] v);
      if (v > CMD_HI) return CMD_HI[7:0];
      if (v < CMD_LO) return CMD_LO[7:0];
      return v[7:0];
   endfunction

   // timekeeping state
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] last_frame_ff, last_frame_in;
   logic [TIME_W-1:0] last_range_ff, last_range_in;
   logic              frame_seen_ff, frame_seen_in;
   logic              alarm_ff, alarm_in;

   // per-item work registers
   drive_mode_type          mode_ff, mode_in;
   logic [6:0]              speed_ff, speed_in;
   logic                    online_ff, online_in;
   logic [7:0]              pan_ff, pan_in;
   logic [7:0]              tilt_ff, tilt_in;
   logic                    report_ff, report_in;
   logic [7:0]              rbyte_ff, rbyte_in;
   logic signed [SUM_W-1:0] tx_ff, tx_in;
   logic signed [SUM_W-1:0] ty_ff, ty_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   rsp_type                 rsp_data_ff, rsp_in;

   logic [TIME_W-1:0]       link_age;
   logic [TIME_W-1:0]       range_age;
   logic                    report_due;
   logic                    spin_l;
   logic                    spin_r;
   logic [7:0]              joy_x_idx;
   logic [7:0]              joy_y_idx;
   logic [7:0]              pan_idx;
   logic [7:0]              tilt_idx;
   logic signed [7:0]       tx_dz;
   logic signed [7:0]       ty_dz;
   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [QUOT_W-1:0]       quot;
   logic signed [SUM_W-1:0] tx_adj;
   logic signed [SUM_W-1:0] ty_fin;
   logic [SUM_W-1:0]        ax;

   assign joy_x_idx = req_data.joy_x;
   assign joy_y_idx = req_data.joy_y;
   assign pan_idx   = req_data.pan_stick;
   assign tilt_idx  = apply_deadzone(req_data.tilt_stick, cfg.tilt_deadzone);

   always_comb begin
      frame_seen_in = frame_seen_ff | req_data.frame_arrived;
      last_frame_in = req_data.frame_arrived ? elapsed_ff : last_frame_ff;
      link_age      = elapsed_ff - last_frame_in;
      online_in     = frame_seen_in && (link_age < TIME_W'(cfg.link_timeout_ms));
      range_age     = elapsed_ff - last_range_ff;
      report_due    = (range_age >= TIME_W'(RANGE_PERIOD_MS));
      elapsed_in    = elapsed_ff + TIME_W'(cfg.tick_ms);

      spin_l = req_data.spin_left_button && !req_data.spin_right_button;
      spin_r = req_data.spin_right_button && !req_data.spin_left_button;
      if (!online_in) begin
         mode_in = MODE_STOP;
      end else if (spin_l) begin
         mode_in = MODE_SPIN_LEFT;
      end else if (spin_r) begin
         mode_in = MODE_SPIN_RIGHT;
      end else begin
         mode_in = MODE_MECANUM;
      end
      speed_in = (mode_in == MODE_SPIN_LEFT || mode_in == MODE_SPIN_RIGHT) ?
                 cfg.turn_rate : 7'd0;

      tx_dz = apply_deadzone(SCALE_LUT[joy_x_idx], cfg.joy_deadzone);
      ty_dz = apply_deadzone(SCALE_LUT[joy_y_idx], cfg.joy_deadzone);
      if (mode_in == MODE_MECANUM) begin
         tx_in = {{(SUM_W-8){tx_dz[7]}}, tx_dz};
         ty_in = {{(SUM_W-8){ty_dz[7]}}, ty_dz};
      end else begin
         tx_in = '0;
         ty_in = '0;
      end

      pan_in  = online_in ? PAN_LUT[pan_idx] : 8'd0;
      tilt_in = online_in ? TILT_LUT[tilt_idx] : 8'd0;

      report_in     = report_due;
      last_range_in = report_due ? elapsed_ff : last_range_ff;
      if (!report_due) begin
         rbyte_in = 8'd0;
         alarm_in = alarm_ff;
      end else if (req_data.range_failed) begin
         rbyte_in = 8'd0;
         alarm_in = 1'b0;
      end else begin
         rbyte_in = (req_data.range_cm > 16'(RANGE_BYTE_MAX)) ?
                    8'(RANGE_BYTE_MAX) : req_data.range_cm[7:0];
         alarm_in = (req_data.range_cm < cfg.near_threshold_cm);
      end
   end

   // shared multiplier; quotient by 100 via reciprocal
   assign quot   = prod_ff[PROD_W-1:DIV100_SHIFT];
   assign tx_adj = tx_ff + $signed({1'b0, quot});
   assign ty_fin = ty_ff + $signed({1'b0, quot});
   assign ax     = tx_adj[SUM_W-1] ? SUM_W'(-tx_adj) : SUM_W'(tx_adj);

   always_comb begin
      case (cmd.mul_op)
         MUL_TY_FC: begin
            mul_a = (ty_ff > 0) ? MUL_A_W'(ty_ff) : '0;
            mul_b = MUL_B_W'(cfg.forward_comp_pct);
         end
         MUL_RECIP: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = DIV100_RECIP;
         end
         MUL_AX_SC: begin
            mul_a = MUL_A_W'(ax);
            mul_b = MUL_B_W'(cfg.strafe_comp_pct);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      rsp_in.drive_mode   = mode_ff;
      rsp_in.drive_x      = clamp_cmd(tx_ff);
      rsp_in.drive_y      = clamp_cmd(ty_fin);
      rsp_in.drive_speed  = speed_ff;
      rsp_in.servo_update = online_ff;
      rsp_in.pan_angle    = pan_ff;
      rsp_in.tilt_angle   = tilt_ff;
      rsp_in.range_report = report_ff;
      rsp_in.range_byte   = rbyte_ff;
      rsp_in.near_alarm   = alarm_ff;
      rsp_in.link_online  = online_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff    <= '0;
         last_frame_ff <= '0;
         last_range_ff <= '0;
         frame_seen_ff <= 1'b0;
         alarm_ff      <= 1'b0;
      end else if (cmd.capture) begin
         elapsed_ff    <= elapsed_in;
         last_frame_ff <= last_frame_in;
         last_range_ff <= last_range_in;
         frame_seen_ff <= frame_seen_in;
         alarm_ff      <= alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= mode_in;
         speed_ff  <= speed_in;
         online_ff <= online_in;
         pan_ff    <= pan_in;
         tilt_ff   <= tilt_in;
         report_ff <= report_in;
         rbyte_ff  <= rbyte_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
      end else if (cmd.adjust_x) begin
         tx_ff <= tx_adj;
      end
      // hold the last quotient while the result waits for the output slot
      if (cmd.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   `MJCM_ASSERT_NEXT(a_no_motion_off_mecanum, clock, reset, cmd.load_out && (mode_ff != MODE_MECANUM), rsp_data_ff.drive_x == 8'sd0 && rsp_data_ff.drive_y == 8'sd0)
   `MJCM_ASSERT_NEXT(a_offline_servo_zero, clock, reset, cmd.load_out && !online_ff, rsp_data_ff.pan_angle == 8'd0 && rsp_data_ff.tilt_angle == 8'd0 && rsp_data_ff.drive_mode == MODE_STOP)
   `MJCM_ASSERT_IMPL(a_no_speed_in_mecanum, clock, reset, cmd.load_out && (mode_ff == MODE_MECANUM), speed_ff == 7'd0)

endmodule

FILE: rtl/mecanum_joystick_command_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum joystick command mixer
// Each item goes from transfer in to result in the output register through
// a capture step, four passes through the single shared 15x13 multiplier
// (forward compensation, its divide by 100, strafe compensation, its divide
// by 100) and a load step that waits until the output slot is free. A new
// item is taken the cycle after the load, even while the previous result
// still waits on rsp_ready. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module mecanum_joystick_command_mixer import mjcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type      cfg;
   ctrl_cmd_type cmd;

   mjcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mjcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mjcm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
